### rtl/sem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_pkg: shared types for the Sobel edge magnitude block
// Command and status records between the controller and the datapath.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int PixW = 24;

  localparam logic [0:0] CfgWidth  = 1'b0;
  localparam logic [0:0] CfgHeight = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic        load;      // accept input beat into stage registers
    logic        rd_mem;    // issue line store read
    logic        shift_win; // shift window, write line stores
    logic        drain_rd;  // read line stores for drain columns
    logic        drain_mode;// compute from drain taps
    logic        start_cmp; // begin gradient computation
    logic        use_left;  // emit from left-shifted window
  } sem_cmd_t;

  typedef struct packed {
    logic busy;   // magnitude unit working
    logic done;   // result available in output register stage
  } sem_sts_t;

  function automatic logic [8:0] pix_ch(input logic [PixW-1:0] p, input int ch);
    pix_ch = {1'b0, p[16-8*ch +: 8]};
  endfunction

endpackage
`default_nettype wire

### rtl/sem_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_sqrt: rounded integer square root with clamp
// One result bit per cycle, then a rounding step; restoring method.
// ----------------------------------------------------------------------------
module sem_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [20:0] sum_in,
  output logic             busy,
  output logic             done,
  output logic [7:0]       root
);

  logic [20:0] s_r, s_nxt;
  logic [7:0]  q_r, q_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        sat_r, sat_nxt;
  logic [7:0]  trial;
  logic [15:0] sq;
  logic [16:0] rem;

  always_comb begin
    trial = q_r | (8'd1 << (cnt_r[2:0]));
    sq    = trial * trial;
    rem   = s_r[16:0] - {1'b0, q_r} * {9'd0, q_r};
  end

  always_comb begin
    s_nxt = s_r; q_nxt = q_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    done_nxt = 1'b0; sat_nxt = sat_r;
    if (start) begin
      s_nxt = sum_in; q_nxt = 8'd0; cnt_nxt = 4'd7; busy_nxt = 1'b1;
      sat_nxt = sum_in > 21'd65280;
    end else if (busy_r) begin
      if (cnt_r[3]) begin
        // rounding step: n^2 + n < s rounds up
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (sat_r) q_nxt = 8'd255;
        else if (rem > {9'd0, q_r}) q_nxt = q_r + 8'd1;
      end else begin
        if ({5'd0, sq} <= s_r) q_nxt = trial;
        cnt_nxt = cnt_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= 4'd0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    s_r <= s_nxt; q_r <= q_nxt; sat_r <= sat_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = q_r;

endmodule
`default_nettype wire

### rtl/sem_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_datapath: line stores, window and gradient arithmetic
// Holds both line stores, the 3x3 window and three magnitude units.
// ----------------------------------------------------------------------------
module sem_datapath #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sem_pkg::sem_cmd_t    cmd,
  input  wire logic [AW-1:0]        col,
  input  wire logic [AW-1:0]        dcol,     // drain read column
  input  wire logic [3:0]           mask,     // top,bottom,left,right valid
  input  wire logic [sem_pkg::PixW-1:0] pix_in,
  output sem_pkg::sem_sts_t         sts,
  output logic [7:0]                red_edge,
  output logic [7:0]                green_edge,
  output logic [7:0]                blue_edge
);

  localparam int PW = sem_pkg::PixW;

  logic [PW-1:0] mem_a [MAX_WIDTH];
  logic [PW-1:0] mem_b [MAX_WIDTH];
  logic [PW-1:0] top_r, mid_r, pix_r;
  logic [PW-1:0] win_r [9];
  logic [PW-1:0] tap   [9];
  logic [AW-1:0] col_r;
  logic [1:0]    dph_r;
  logic [PW-1:0] dtop_r [3];
  logic [PW-1:0] dmid_r [3];
  logic [AW-1:0] rd_addr;
  logic [20:0]   sum_r [3];
  logic [2:0]    busy_v, done_v;
  logic [7:0]    root_v [3];

  // Line store read: the input column, or one of the drain columns
  always_comb begin
    rd_addr = cmd.drain_rd ? dcol : col;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r <= pix_in;
      col_r <= col;
    end
    if (cmd.rd_mem || cmd.drain_rd) begin
      top_r <= mem_b[rd_addr];
      mid_r <= mem_a[rd_addr];
    end
    if (cmd.shift_win) begin
      mem_b[col_r] <= mid_r;
      mem_a[col_r] <= pix_r;
    end
  end

  // drain taps gathered column by column over three reads
  always_ff @(posedge clk) begin
    if (!rst_n) dph_r <= 2'd0;
    else if (cmd.drain_rd) dph_r <= (dph_r == 2'd2) ? 2'd0 : dph_r + 2'd1;
    else if (!cmd.drain_mode) dph_r <= 2'd0;
  end

  logic          dcap_r;
  logic [1:0]    dslot_r;
  always_ff @(posedge clk) begin
    if (!rst_n) dcap_r <= 1'b0;
    else dcap_r <= cmd.drain_rd;
    dslot_r <= dph_r;
    if (dcap_r) begin
      dtop_r[dslot_r] <= top_r;
      dmid_r[dslot_r] <= mid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) win_r[k] <= '0;
    end else if (cmd.shift_win) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i*3]   <= win_r[i*3+1];
        win_r[i*3+1] <= win_r[i*3+2];
      end
      win_r[2] <= top_r;
      win_r[5] <= mid_r;
      win_r[8] <= pix_r;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (cmd.drain_mode) begin
        tap[j] = dtop_r[j]; tap[3+j] = dmid_r[j]; tap[6+j] = '0;
      end else if (cmd.use_left) begin
        tap[j]   = (j == 2) ? '0 : win_r[j+1];
        tap[3+j] = (j == 2) ? '0 : win_r[4+j];
        tap[6+j] = (j == 2) ? '0 : win_r[7+j];
      end else begin
        tap[j] = win_r[j]; tap[3+j] = win_r[3+j]; tap[6+j] = win_r[6+j];
      end
    end
  end

  // gradient per channel; taps masked at the frame borders
  always_ff @(posedge clk) begin
    logic signed [11:0] gx, gy;
    logic [PW-1:0] t [9];
    for (int k = 0; k < 9; k++) begin
      t[k] = tap[k];
      if (k < 3 && !mask[3]) t[k] = '0;
      if (k > 5 && !mask[2]) t[k] = '0;
      if (k % 3 == 0 && !mask[1]) t[k] = '0;
      if (k % 3 == 2 && !mask[0]) t[k] = '0;
    end
    for (int ch = 0; ch < 3; ch++) begin
      gx = $signed({3'd0, sem_pkg::pix_ch(t[2], ch)}) - $signed({3'd0, sem_pkg::pix_ch(t[0], ch)})
         + $signed({2'd0, sem_pkg::pix_ch(t[5], ch), 1'b0})
         - $signed({2'd0, sem_pkg::pix_ch(t[3], ch), 1'b0})
         + $signed({3'd0, sem_pkg::pix_ch(t[8], ch)}) - $signed({3'd0, sem_pkg::pix_ch(t[6], ch)});
      gy = $signed({3'd0, sem_pkg::pix_ch(t[6], ch)}) - $signed({3'd0, sem_pkg::pix_ch(t[0], ch)})
         + $signed({2'd0, sem_pkg::pix_ch(t[7], ch), 1'b0})
         - $signed({2'd0, sem_pkg::pix_ch(t[1], ch), 1'b0})
         + $signed({3'd0, sem_pkg::pix_ch(t[8], ch)}) - $signed({3'd0, sem_pkg::pix_ch(t[2], ch)});
      if (cmd.start_cmp)
        sum_r[ch] <= 21'(gx * gx) + 21'(gy * gy);
    end
  end

  logic start_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) start_d_r <= 1'b0;
    else start_d_r <= cmd.start_cmp;
  end

  for (genvar g = 0; g < 3; g++) begin : g_sqrt
    sem_sqrt u_sqrt (
      .clk(clk), .rst_n(rst_n), .start(start_d_r), .sum_in(sum_r[g]),
      .busy(busy_v[g]), .done(done_v[g]), .root(root_v[g])
    );
  end

  assign sts.busy  = busy_v[0] | start_d_r | cmd.start_cmp;
  assign sts.done  = done_v[0];
  assign red_edge   = root_v[0];
  assign green_edge = root_v[1];
  assign blue_edge  = root_v[2];

endmodule
`default_nettype wire

### rtl/sem_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_ctrl: frame sequencer
// Tracks rows, columns and results issued; steps the datapath per beat.
// ----------------------------------------------------------------------------
module sem_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int AW = 10,
  parameter int HW = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_func,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_frame_end,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [12:0]        cfg_data,
  input  wire logic               cfg_hit,
  output sem_pkg::sem_cmd_t       cmd,
  input  wire sem_pkg::sem_sts_t  sts,
  output logic [AW-1:0]           col,
  output logic [AW-1:0]           dcol,
  output logic [3:0]              mask
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DRD   = 3'd3;
  localparam logic [2:0] S_DWAIT = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]  st_r, st_nxt;
  logic [10:0] fw_r;
  logic [12:0] fh_r;
  logic [AW:0] w;
  logic [HW:0] h;
  logic [HW:0] row_r, row_nxt;
  logic [AW-1:0] col_r, col_nxt;
  logic [AW:0] ecol_r, ecol_nxt;   // emitted column
  logic [HW:0] erow_r, erow_nxt;   // emitted row
  logic [1:0]  dcnt_r, dcnt_nxt;
  logic        pre_r, pre_nxt;      // left-shifted emit before shift
  logic        post_r, post_nxt;    // emit after shift
  logic        fe_r, fe_nxt;
  logic        drain_r, drain_nxt;
  logic [3:0]  mask_r, mask_nxt;
  logic        emit, last_e;

  always_comb begin
    if (fw_r == 11'd0) w = (AW+1)'(1);
    else if ({21'd0, fw_r} > 32'(MAX_WIDTH)) w = (AW+1)'(MAX_WIDTH);
    else w = (AW+1)'(fw_r);
    if (fh_r == 13'd0) h = (HW+1)'(1);
    else if ({19'd0, fh_r} > 32'(MAX_HEIGHT)) h = (HW+1)'(MAX_HEIGHT);
    else h = (HW+1)'(fh_r);
  end

  // emit the pixel one row plus one behind the input
  assign emit   = (row_r > (HW+1)'(1)) || (row_r == (HW+1)'(1) && col_r != '0);
  assign last_e = (erow_r + (HW+1)'(1) == h) && (ecol_r + (AW+1)'(1) == w);

  always_comb begin
    st_nxt = st_r; row_nxt = row_r; col_nxt = col_r; ecol_nxt = ecol_r; erow_nxt = erow_r;
    dcnt_nxt = dcnt_r; pre_nxt = pre_r; post_nxt = post_r; fe_nxt = fe_r;
    drain_nxt = drain_r; mask_nxt = mask_r;
    cmd = '0;
    cmd.drain_mode = drain_r;
    cmd.use_left = pre_r;
    in_stall = 1'b1;
    cfg_ready = (st_r == S_IDLE);
    unique case (st_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (row_r >= h) begin
            dcnt_nxt = 2'd0;
            if (erow_r + (HW+1)'(1) < h) begin
              // end of the row above the bottom one still sits in the window
              pre_nxt = 1'b1;
              drain_nxt = 1'b0;
              st_nxt = S_CMP;
            end else begin
              drain_nxt = 1'b1;
              st_nxt = S_DRD;
            end
          end else if (!in_func) begin
            cmd.load = 1'b1;
            cmd.rd_mem = 1'b1;
            // at column 0 the result for the previous row's end comes first
            pre_nxt  = emit && (col_r == '0) && (w != (AW+1)'(1));
            post_nxt = emit && !((col_r == '0) && (w != (AW+1)'(1)));
            drain_nxt = 1'b0;
            st_nxt = S_RD;
          end
        end
      end
      S_RD: st_nxt = pre_r ? S_CMP : S_SHIFT;
      S_SHIFT: begin
        cmd.shift_win = 1'b1;
        if ((AW+1)'(col_r) + (AW+1)'(1) >= w) begin
          col_nxt = '0; row_nxt = row_r + 1'b1;
        end else col_nxt = col_r + 1'b1;
        st_nxt = post_r ? S_CMP : S_IDLE;
        pre_nxt = 1'b0;
      end
      S_DRD: begin
        cmd.drain_rd = 1'b1;
        dcnt_nxt = dcnt_r + 2'd1;
        if (dcnt_r == 2'd2) st_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        dcnt_nxt = dcnt_r + 2'd1;
        if (dcnt_r == 2'd0) st_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.start_cmp = 1'b1;
        st_nxt = S_WAIT;
        fe_nxt = last_e;
        if (ecol_r + (AW+1)'(1) == w) begin
          ecol_nxt = '0; erow_nxt = erow_r + 1'b1;
        end else ecol_nxt = ecol_r + 1'b1;
      end
      S_WAIT: if (sts.done) st_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          if (fe_r) begin
            row_nxt = '0; col_nxt = '0; ecol_nxt = '0; erow_nxt = '0;
          end
          st_nxt = (pre_r && row_r < h) ? S_SHIFT : S_IDLE;
          if (row_r >= h) pre_nxt = 1'b0;
          drain_nxt = 1'b0;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_IDLE || st_r == S_RD) begin
      mask_nxt[3] = (pre_r ? erow_r : erow_r) != '0;
      mask_nxt[2] = erow_r + (HW+1)'(1) < h;
      mask_nxt[1] = ecol_r != '0;
      mask_nxt[0] = ecol_r + (AW+1)'(1) < w;
    end
    if (st_r == S_IDLE && in_valid && row_r >= h && erow_r >= h) begin
      st_nxt = S_IDLE;
      row_nxt = '0; col_nxt = '0; ecol_nxt = '0; erow_nxt = '0;
    end
    if (cfg_valid && cfg_ready && cfg_hit) begin
      row_nxt = '0; col_nxt = '0; ecol_nxt = '0; erow_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; fw_r <= 11'd1024; fh_r <= 13'd1;
      row_r <= '0; col_r <= '0; ecol_r <= '0; erow_r <= '0;
      dcnt_r <= '0; pre_r <= 1'b0; post_r <= 1'b0; fe_r <= 1'b0; drain_r <= 1'b0;
      mask_r <= '0;
    end else begin
      st_r <= st_nxt; row_r <= row_nxt; col_r <= col_nxt;
      ecol_r <= ecol_nxt; erow_r <= erow_nxt; dcnt_r <= dcnt_nxt;
      pre_r <= pre_nxt; post_r <= post_nxt; fe_r <= fe_nxt; drain_r <= drain_nxt;
      mask_r <= mask_nxt;
      if (cfg_valid && cfg_ready && cfg_hit) begin
        if (cfg_index == sem_pkg::CfgWidth) fw_r <= cfg_data[10:0];
        else fh_r <= cfg_data;
      end
    end
  end

  // drain column: centre minus one, plus phase
  logic [AW:0] dc;
  always_comb begin
    dc = ecol_r + (AW+1)'(dcnt_r) - (AW+1)'(1);
    dcol = (dc < w) ? dc[AW-1:0] : '0;
  end

  assign col = col_r;
  assign mask = mask_r;
  assign out_valid = (st_r == S_OUT);
  assign out_frame_end = fe_r;

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> st_r == S_IDLE) else $error("cfg taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> st_r == S_IDLE) else $error("input taken while busy");

endmodule
`default_nettype wire

### rtl/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb: streaming 3x3 Sobel magnitude for RGB pixels
// Pixels enter on in_*, results leave on out_*, cfg_* sets frame size.
// ----------------------------------------------------------------------------
// Usage: write frame_width (index 0) and frame_height (index 1) while idle;
// each write restarts the frame. Send pixels in raster order (in_func = 0),
// then flush beats (in_func = 1) to drain the last row plus one result.
// A result follows the input by one row plus one pixel.
// One item is handled at a time; no beat is taken before the last is done.
// A pixel beat with a result passes line store read, window shift,
// gradient, eight-step square root plus rounding and output beat; one
// without a result only the read and shift. A drain beat's taps come
// from three line store reads, but for the one served from the window;
// a flush before the frame ends does no work. Out stalls add their length.
// in_stall is high while a beat is in work and while out_valid waits;
// a stalled result holds. Reset clears counters and window, sets width
// 1024 and height 1; line store contents are undefined until written.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red_edge,
  output logic [7:0]       out_green_edge,
  output logic [7:0]       out_blue_edge,
  output logic             out_frame_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  sem_pkg::sem_cmd_t cmd;
  sem_pkg::sem_sts_t sts;
  logic [AW-1:0] col, dcol;
  logic [3:0]    mask;

  sem_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .AW(AW), .HW(HW)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .out_valid(out_valid), .out_stall(out_stall),
    .out_frame_end(out_frame_end), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg_hit(1'b1),
    .cmd(cmd), .sts(sts), .col(col), .dcol(dcol), .mask(mask)
  );

  sem_datapath #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .col(col), .dcol(dcol), .mask(mask),
    .pix_in({in_red_in, in_green_in, in_blue_in}), .sts(sts),
    .red_edge(out_red_edge), .green_edge(out_green_edge), .blue_edge(out_blue_edge)
  );

endmodule
`default_nettype wire
